/* sv/stq_pkg.sv */
// Shared types, codes and constants for the sorted timer queue.
// No dependencies; imported by stq_cell and the top level.
package stq_pkg;

  localparam int TIMER_COUNT_DEF = 16;
  localparam int SKEW_LIMIT_DEF  = 1024;
  localparam int U16_FULL        = 65535;

  // input operation codes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_CREATE  = 2'd1;
  localparam logic [1:0] OP_DESTROY = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_NO_FIRE = 2'd2;

  // acknowledge status
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_RANGE  = 2'd1;
  localparam logic [1:0] STAT_ACTIVE = 2'd2;

  // one list slot: timer id, ticks left, reload period
  typedef struct packed {
    logic        valid;
    logic [3:0]  id;
    logic [15:0] rem;
    logic [15:0] rel;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{valid: 1'b0, id: 4'd0, rem: 16'd0, rel: 16'd0};

  // command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_DEC  = 2'd1,
    CMD_INS  = 2'd2,
    CMD_DEL  = 2'd3
  } cell_cmd_t;

endpackage

/* sv/stq_cell.sv */
// One slot of the sorted timer chain: holds one entry and trades it with
// its neighbors on insert and delete. Depends on stq_pkg.
module stq_cell (
  input  logic              clk,
  input  logic              rst,
  input  stq_pkg::cell_cmd_t cmd,
  input  stq_pkg::entry_t   key,
  input  logic [3:0]        del_id,
  input  stq_pkg::entry_t   left,
  input  logic              left_f,
  input  stq_pkg::entry_t   right,
  input  logic              g_in,
  output stq_pkg::entry_t   ent,
  output logic              f_out,
  output logic              g_out
);
  import stq_pkg::*;

  entry_t ent_next;

  // slot is past the insert point: empty or holds a strictly larger count
  assign f_out = !ent.valid || (ent.rem > key.rem);
  // delete point reached at or before this slot
  assign g_out = g_in || (ent.valid && (ent.id == del_id));

  always_comb begin
    ent_next = ent;
    case (cmd)
      CMD_DEC: begin
        if (ent.valid && (ent.rem != 16'd0)) begin
          ent_next.rem = ent.rem - 16'd1;
        end
      end
      CMD_INS: begin
        if (left_f) begin
          ent_next = left;
        end else if (f_out) begin
          ent_next = key;
        end
      end
      CMD_DEL: begin
        if (g_out) begin
          ent_next = right;
        end
      end
      default: begin
        ent_next = ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= ENTRY_EMPTY;
    end else begin
      ent <= ent_next;
    end
  end

endmodule

/* sv/sorted_software_timer_queue_unit.sv */
// Sorted timer queue with autoreload, built as a chain of TIMER_COUNT cells.
// Depends on stq_pkg and stq_cell.
//
// Up to TIMER_COUNT timers sit in a chain of cells kept sorted by ticks left;
// equal counts keep insertion order. An input transfer is one of: tick (op 0),
// create (op 1, timeout 1..65534-SKEW_LIMIT, reload 0 for single shot) or
// destroy (op 2). Create and destroy, and the unused op 3, give one
// acknowledge each; it is loaded into the output register from the
// acknowledge state that follows the input transfer, once the output is free.
// A tick counts every cell down at its input transfer, then fires the
// zero entries at the head of the chain one per cycle while the output is
// free, each giving an expiry result; an autoreload timer is re-inserted in
// sorted order before the next fire, which holds the firing back. A tick
// with nothing due gives one result of kind 2. The input stalls until the
// current item is fully handed to the output register; the output register
// lets the next input transfer go on while the final result still waits
// downstream. tick_count carries the wrapping tick counter after the item.
// No clearing pass is needed at reset.
module sorted_software_timer_queue_unit #(
  parameter int TIMER_COUNT = stq_pkg::TIMER_COUNT_DEF,
  parameter int SKEW_LIMIT  = stq_pkg::SKEW_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [3:0]  timer_id,
  input  logic [15:0] timeout,
  input  logic [15:0] reload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [3:0]  timer_id_res,
  output logic [1:0]  status,
  output logic [31:0] tick_count,
  output logic        last
);
  import stq_pkg::*;

  // lowest refused timeout above the legal range
  localparam logic [16:0] TMO_LIMIT = 17'(U16_FULL - SKEW_LIMIT);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FIRE = 4'b0010,
    S_INS  = 4'b0100,
    S_ACK  = 4'b1000
  } state_t;

  state_t      state;
  logic [31:0] global_ticks;
  entry_t      key_q;       // pending reload re-insert
  logic        pend_last;   // the re-insert closes the tick
  logic [3:0]  ack_id;
  logic [1:0]  ack_status;

  // chain wiring; slot TIMER_COUNT is a permanently empty pad
  entry_t            chain  [TIMER_COUNT+1];
  entry_t            left_e [TIMER_COUNT];
  logic              left_f [TIMER_COUNT];
  logic              f_vec  [TIMER_COUNT];
  logic              g_vec  [TIMER_COUNT+1];
  logic [TIMER_COUNT-1:0] vmask;

  cell_cmd_t   cell_cmd;
  entry_t      key;
  logic [3:0]  del_id;

  logic        in_acc;
  logic        out_free;
  logic        out_load;
  logic        active_hit;
  logic        bad_range;
  logic [1:0]  create_status;
  logic        head_fire;
  logic        more_fire;

  assign chain[TIMER_COUNT] = ENTRY_EMPTY;
  assign g_vec[0] = 1'b0;

  for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_e[i] = ENTRY_EMPTY;
      assign left_f[i] = 1'b0;
    end else begin : g_body
      assign left_e[i] = chain[i-1];
      assign left_f[i] = f_vec[i-1];
    end

    stq_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cell_cmd),
      .key    (key),
      .del_id (del_id),
      .left   (left_e[i]),
      .left_f (left_f[i]),
      .right  (chain[i+1]),
      .g_in   (g_vec[i]),
      .ent    (chain[i]),
      .f_out  (f_vec[i]),
      .g_out  (g_vec[i+1])
    );

    assign vmask[i] = chain[i].valid;
  end

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  // a result enters the output register this cycle
  assign out_load = out_free && ((state == S_ACK) || (state == S_FIRE));

  // an active timer is exactly one that sits in some cell
  always_comb begin
    active_hit = 1'b0;
    for (int i = 0; i < TIMER_COUNT; i++) begin
      if (chain[i].valid && (chain[i].id == timer_id)) begin
        active_hit = 1'b1;
      end
    end
  end

  assign bad_range = (timeout == 16'd0) || ({1'b0, timeout} >= TMO_LIMIT) ||
                     (int'(timer_id) >= TIMER_COUNT);

  always_comb begin
    if (bad_range) begin
      create_status = STAT_RANGE;
    end else if (active_hit) begin
      create_status = STAT_ACTIVE;
    end else begin
      create_status = STAT_OK;
    end
  end

  // zero counts form a prefix of the sorted chain
  assign head_fire = chain[0].valid && (chain[0].rem == 16'd0);
  assign more_fire = chain[1].valid && (chain[1].rem == 16'd0);

  // chain command, insert key and delete id
  always_comb begin
    cell_cmd = CMD_HOLD;
    key      = '{valid: 1'b1, id: timer_id, rem: timeout, rel: reload};
    del_id   = timer_id;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_TICK:    cell_cmd = CMD_DEC;
            OP_CREATE:  cell_cmd = (create_status == STAT_OK) ? CMD_INS : CMD_HOLD;
            OP_DESTROY: cell_cmd = CMD_DEL;
            default:    cell_cmd = CMD_HOLD;
          endcase
        end
      end
      S_FIRE: begin
        del_id = chain[0].id;
        if (out_free && head_fire) begin
          cell_cmd = CMD_DEL;   // pop the head
        end
      end
      S_INS: begin
        key      = key_q;
        cell_cmd = CMD_INS;
      end
      default: begin
        cell_cmd = CMD_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      global_ticks <= 32'd0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            ack_id <= timer_id;
            if (op == OP_TICK) begin
              global_ticks <= global_ticks + 32'd1;
              state        <= S_FIRE;
            end else begin
              ack_status <= (op == OP_CREATE) ? create_status : STAT_OK;
              state      <= S_ACK;
            end
          end
        end
        S_ACK: begin
          if (out_free) begin
            kind         <= KIND_ACK;
            timer_id_res <= ack_id;
            status       <= ack_status;
            tick_count   <= global_ticks;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_FIRE: begin
          if (out_free) begin
            status     <= STAT_OK;
            tick_count <= global_ticks;
            if (head_fire) begin
              kind         <= KIND_EXPIRED;
              timer_id_res <= chain[0].id;
              last         <= !more_fire;
              pend_last    <= !more_fire;
              key_q        <= '{valid: 1'b1, id: chain[0].id, rem: chain[0].rel,
                                rel: chain[0].rel};
              if (chain[0].rel != 16'd0) begin
                state <= S_INS;
              end else if (!more_fire) begin
                state <= S_IDLE;
              end
            end else begin
              // nothing due on this tick
              kind         <= KIND_NO_FIRE;
              timer_id_res <= 4'd0;
              last         <= 1'b1;
              state        <= S_IDLE;
            end
          end
        end
        S_INS: begin
          state <= pend_last ? S_IDLE : S_FIRE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // sortedness of adjacent occupied cells
  logic sorted_ok;
  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 0; i + 1 < TIMER_COUNT; i++) begin
      if (chain[i+1].valid && (chain[i].rem > chain[i+1].rem)) begin
        sorted_ok = 1'b0;
      end
    end
  end

  // an accepted item always moves the block out of idle, so the input stalls
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // occupied cells form a prefix of the chain
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (vmask & (vmask + TIMER_COUNT'(1))) == '0)
    else $error("gap in timer chain");

  // chain stays ordered by ticks left
  a_sorted: assert property (@(posedge clk) disable iff (rst) sorted_ok)
    else $error("timer chain out of order");

  // the no-expiry result always closes its tick
  a_no_fire_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_NO_FIRE) |-> last)
    else $error("no-expiry result without last");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for sorted_software_timer_queue_unit.
// Depends on stq_pkg and the unit's RTL; carries its own model of the sorted timer list.
module tb_top;
  import stq_pkg::*;

  // op 3 is unused by the block but still answered with an acknowledge
  localparam logic [1:0]  OP_SPARE     = 2'd3;
  // lowest timeout value above the legal range, which a create refuses
  localparam int unsigned TMO_CEILING  = U16_FULL - SKEW_LIMIT_DEF;
  localparam int          LIMIT_CYCLES = 200000;
  localparam int          HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int          DRAIN_CYCLES = 60;   // extra drain after the backlog and owed results are empty
  localparam int          IDLE_PCT     = 11;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  id;
    logic [15:0] tmo;
    logic [15:0] rld;
  } timer_cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  id;
    logic [1:0]  stat;
    logic [31:0] ticks;
    logic        last_flag;
  } timer_result_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [1:0]  op           = '0;
  logic [3:0]  timer_id     = '0;
  logic [15:0] timeout      = '0;
  logic [15:0] reload       = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [1:0]  kind;
  logic [3:0]  timer_id_res;
  logic [1:0]  status;
  logic [31:0] tick_count;
  logic        last;

  sorted_software_timer_queue_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .timer_id     (timer_id),
    .timeout      (timeout),
    .reload       (reload),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .timer_id_res (timer_id_res),
    .status       (status),
    .tick_count   (tick_count),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Timer list model: ticks left, reload period and armed flag per id, plus the
  // ids of the armed timers in firing order (ascending ticks left, ties FIFO).
  // ---------------------------------------------------------------------------
  logic [15:0]   tl_left   [16];
  logic [15:0]   tl_period [16];
  bit            tl_armed  [16];
  logic [3:0]    tl_order  [$];
  logic [31:0]   tl_ticks  = '0;

  timer_cmd_t    cmd_backlog   [$];  // items not yet offered to the block
  timer_result_t owed_results  [$];  // results the block still has to produce

  int unsigned   accepted      = 0;  // input transfers so far
  int unsigned   cycle_count   = 0;
  int unsigned   fail_count    = 0;
  int unsigned   results_seen  = 0;
  int unsigned   ticks_sent    = 0;
  int unsigned   expiries      = 0;
  int unsigned   refusals      = 0;
  int unsigned   biggest_burst = 0;

  timer_cmd_t    next_cmd;
  timer_result_t seen, want;
  int unsigned   hold_left     = 0;
  bit            hold_done     = 1'b0;

  // stretch of the run where neither side idles
  wire calm = (accepted >= 95) && (accepted < 125);

  initial begin
    for (int i = 0; i < 16; i++) begin
      tl_left[i]   = '0;
      tl_period[i] = '0;
      tl_armed[i]  = 1'b0;
    end
  end

  // place an armed id behind every entry with no more ticks left than it
  function automatic void insert_by_ticks_left(input logic [3:0] id);
    int pos;
    pos = 0;
    while (pos < tl_order.size() && tl_left[tl_order[pos]] <= tl_left[id])
      pos++;
    tl_order.insert(pos, id);
  endfunction

  function automatic void owe(input logic [1:0] k, input logic [3:0] id,
                              input logic [1:0] s, input logic lst);
    owed_results.push_back('{kind: k, id: id, stat: s, ticks: tl_ticks,
                             last_flag: lst});
  endfunction

  // advance the model by one accepted transfer and queue what it must produce
  task automatic advance_timer_model(input timer_cmd_t c);
    logic [3:0] fired [$];
    logic [1:0] stat;
    int         hit;
    case (c.op)
      OP_TICK: begin
        ticks_sent++;
        tl_ticks = tl_ticks + 32'd1;
        foreach (tl_order[i])
          if (tl_left[tl_order[i]] != 0) tl_left[tl_order[i]]--;
        while (fired.size() < tl_order.size() && tl_left[tl_order[fired.size()]] == 0)
          fired.push_back(tl_order[fired.size()]);
        if (fired.size() == 0) begin
          owe(KIND_NO_FIRE, 4'd0, STAT_OK, 1'b1);
        end else begin
          foreach (fired[i])
            owe(KIND_EXPIRED, fired[i], STAT_OK, i == fired.size() - 1);
          expiries += fired.size();
          if (fired.size() > biggest_burst) biggest_burst = fired.size();
          repeat (fired.size()) void'(tl_order.pop_front());
          foreach (fired[i]) tl_armed[fired[i]] = 1'b0;
          // autoreload timers go back in, in the order they fired
          foreach (fired[i]) begin
            if (tl_period[fired[i]] != 0) begin
              tl_left[fired[i]]  = tl_period[fired[i]];
              tl_armed[fired[i]] = 1'b1;
              insert_by_ticks_left(fired[i]);
            end
          end
        end
      end
      OP_CREATE: begin
        // range check wins over the already-armed check
        if (c.tmo == 0 || c.tmo >= TMO_CEILING) stat = STAT_RANGE;
        else if (tl_armed[c.id])               stat = STAT_ACTIVE;
        else                                   stat = STAT_OK;
        if (stat == STAT_OK) begin
          tl_left[c.id]   = c.tmo;
          tl_period[c.id] = c.rld;
          tl_armed[c.id]  = 1'b1;
          insert_by_ticks_left(c.id);
        end else begin
          refusals++;
        end
        owe(KIND_ACK, c.id, stat, 1'b1);
      end
      OP_DESTROY: begin
        // idle ids (never armed, or fired single shot) are acknowledged as ok
        if (tl_armed[c.id]) begin
          hit = 0;
          for (int i = 0; i < tl_order.size(); i++)
            if (tl_order[i] == c.id) hit = i;
          tl_order.delete(hit);
          tl_armed[c.id]  = 1'b0;
          tl_left[c.id]   = '0;
          tl_period[c.id] = '0;
        end
        owe(KIND_ACK, c.id, STAT_OK, 1'b1);
      end
      default: owe(KIND_ACK, c.id, STAT_OK, 1'b1);
    endcase
  endtask

  task automatic report_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endtask

  task automatic queue_cmd(input logic [1:0] o, input logic [3:0] id,
                           input logic [15:0] tmo, input logic [15:0] rld);
    cmd_backlog.push_back('{op: o, id: id, tmo: tmo, rld: rld});
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the backlog one item at a time. A new item is loaded only
  // when the slot is empty or the current transfer completes this edge, so a
  // stalled payload never changes.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        next_cmd = cmd_backlog.pop_front();
        in_valid <= 1'b1;
        op       <= next_cmd.op;
        timer_id <= next_cmd.id;
        timeout  <= next_cmd.tmo;
        reload   <= next_cmd.rld;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once the run is under way
  // so the block backs up and stalls its input while the driver keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted >= 40) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Monitor: checks each output transfer against the oldest owed result, then
  // feeds any input transfer of the same edge to the model. No result can come
  // out on the edge that accepts its own input, so this order is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        seen = '{kind: kind, id: timer_id_res, stat: status, ticks: tick_count,
                 last_flag: last};
        results_seen++;
        if (owed_results.size() == 0) begin
          report_failure($sformatf(
            "unexpected result: kind=%0d id=%0d status=%0d ticks=%0d last=%0d",
            seen.kind, seen.id, seen.stat, seen.ticks, seen.last_flag));
        end else begin
          want = owed_results.pop_front();
          if (want !== seen)
            report_failure($sformatf({
              "mismatch: expected kind=%0d id=%0d status=%0d ticks=%0d last=%0d,",
              " got kind=%0d id=%0d status=%0d ticks=%0d last=%0d"},
              want.kind, want.id, want.stat, want.ticks, want.last_flag,
              seen.kind, seen.id, seen.stat, seen.ticks, seen.last_flag));
        end
      end
      if (in_valid && !in_stall) begin
        advance_timer_model('{op: op, id: timer_id, tmo: timeout, rld: reload});
        accepted <= accepted + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    logic [15:0] tmo, rld;

    // directed: empty tick, single shot, range edges, double create, idempotent
    // destroy, spare op, then a tie group mixing reload and single shot
    queue_cmd(OP_TICK,    4'd0,  16'd0,     16'd0);
    queue_cmd(OP_CREATE,  4'd0,  16'd1,     16'd0);
    queue_cmd(OP_TICK,    4'd0,  16'd0,     16'd0);
    queue_cmd(OP_TICK,    4'd0,  16'd0,     16'd0);
    queue_cmd(OP_DESTROY, 4'd0,  16'd0,     16'd0);      // fired single shot is idle
    queue_cmd(OP_CREATE,  4'd5,  16'd0,     16'd7);
    queue_cmd(OP_CREATE,  4'd5,  16'd64511, 16'd0);
    queue_cmd(OP_CREATE,  4'd5,  16'hFFFF,  16'hFFFF);
    queue_cmd(OP_CREATE,  4'd15, 16'd64510, 16'hFFFF);   // largest legal timeout
    queue_cmd(OP_CREATE,  4'd15, 16'd5,     16'd0);      // already armed
    queue_cmd(OP_CREATE,  4'd15, 16'd0,     16'd0);      // range beats armed
    queue_cmd(OP_DESTROY, 4'd15, 16'd0,     16'd0);
    queue_cmd(OP_DESTROY, 4'd15, 16'd0,     16'd0);
    queue_cmd(OP_SPARE,   4'd9,  16'hFFFF,  16'hFFFF);
    queue_cmd(OP_CREATE,  4'd1,  16'd2,     16'd3);
    queue_cmd(OP_CREATE,  4'd2,  16'd2,     16'd1);
    queue_cmd(OP_CREATE,  4'd3,  16'd2,     16'd0);
    queue_cmd(OP_CREATE,  4'd4,  16'd1,     16'd2);
    repeat (4) queue_cmd(OP_TICK, 4'd0, 16'd0, 16'd0);
    queue_cmd(OP_DESTROY, 4'd1,  16'd0,     16'd0);
    queue_cmd(OP_DESTROY, 4'd2,  16'd0,     16'd0);
    queue_cmd(OP_DESTROY, 4'd4,  16'd0,     16'd0);

    // random: mostly short timeouts so timers keep firing; midway a full-house
    // burst arms all sixteen ids to fire on the same tick
    for (int n = 0; n < 110; n++) begin
      if (n == 55) begin
        for (int i = 0; i < 16; i++) queue_cmd(OP_DESTROY, 4'(i), 16'd0, 16'd0);
        for (int i = 0; i < 16; i++)
          queue_cmd(OP_CREATE, 4'(i), 16'd3,
                    $urandom_range(1) ? 16'd0 : 16'($urandom_range(1, 4)));
        // filler fields of burst ticks are random
        repeat (3)
          queue_cmd(OP_TICK, 4'($urandom_range(15)), 16'($urandom), 16'($urandom));
      end
      pick = $urandom_range(9);
      if (pick < 7)       tmo = 16'($urandom_range(1, 6));
      else if (pick == 7) tmo = 16'($urandom);
      else if (pick == 8) tmo = 16'($urandom_range(64505, 65535));
      else                tmo = 16'd0;
      pick = $urandom_range(9);
      if (pick < 4)       rld = 16'd0;
      else if (pick < 8)  rld = 16'($urandom_range(1, 5));
      else                rld = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 45)      queue_cmd(OP_TICK,    4'($urandom), 16'($urandom), 16'($urandom));
      else if (pick < 78) queue_cmd(OP_CREATE,  4'($urandom), tmo, rld);
      else if (pick < 96) queue_cmd(OP_DESTROY, 4'($urandom), tmo, rld);
      else                queue_cmd(OP_SPARE,   4'($urandom), tmo, rld);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || in_valid || owed_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (owed_results.size() != 0)
      report_failure($sformatf("%0d results never arrived", owed_results.size()));

    $display("Covered %0d input transfers (%0d ticks, %0d refused creates), %0d results checked.",
             accepted, ticks_sent, refusals, results_seen);
    $display("Saw %0d expiries, largest single-tick burst %0d; %0d failures.",
             expiries, biggest_burst, fail_count);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
sv/stq_pkg.sv
sv/stq_cell.sv
sv/sorted_software_timer_queue_unit.sv
test/tb_top.sv
